// File: rtl/rws_pkg.sv
// ----------------------------------------------------------------------------
// rws_pkg
// Shared types and constants for the roulette-wheel parent selection unit.
// ----------------------------------------------------------------------------
package rws_pkg;

  localparam int unsigned POP_MAX        = 256;
  localparam int unsigned RAND_FRAC_BITS = 16;

  localparam int unsigned IDX_W  = $clog2(POP_MAX);
  localparam int unsigned CNT_W  = IDX_W + 1;
  localparam int unsigned FIT_W  = 32;
  localparam int unsigned SUM_W  = FIT_W + IDX_W;
  localparam int unsigned PROD_W = SUM_W + RAND_FRAC_BITS;
  localparam int unsigned POP_W  = 9;
  localparam int unsigned RAND_W = 16;
  localparam int unsigned OP_W   = 2;
  localparam int unsigned STAT_W = 2;

  localparam logic [POP_W-1:0] POP_RESET = POP_W'(256);

  typedef enum logic [OP_W-1:0] {
    OP_WRITE       = 2'd0,
    OP_DRAW_FIRST  = 2'd1,
    OP_DRAW_SECOND = 2'd2,
    OP_NONE        = 2'd3
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK         = 2'd0,
    ST_RETRY      = 2'd1,
    ST_ZERO_TOTAL = 2'd2,
    ST_OUT_RANGE  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SUM,
    S_SCALE,
    S_WALK,
    S_DONE
  } state_e;

  typedef struct packed {
    logic capture;
    logic sweep_clr;
    logic issue;
    logic acc_total;
    logic acc_run;
    logic scale;
    logic load_out;
  } rws_cmd_t;

  typedef struct packed {
    logic sweep_end;
    logic rd_pend;
    logic found;
    logic total_zero;
    logic out_busy;
  } rws_stat_t;

endpackage

// File: rtl/rws_ctrl.sv
// ----------------------------------------------------------------------------
// rws_ctrl
// Sequencer for the selection unit: sum sweep, scale, walk sweep, result.
// ----------------------------------------------------------------------------
module rws_ctrl import rws_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic [OP_W-1:0] op_i,
  output logic          in_ready_o,
  input  rws_stat_t     stat_i,
  output rws_cmd_t      cmd_o
);

  state_e state_q, state_d;
  logic   is_draw;

  assign is_draw = (op_e'(op_i) == OP_DRAW_FIRST) || (op_e'(op_i) == OP_DRAW_SECOND);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = is_draw ? S_SUM : S_DONE;
        end
      end
      S_SUM: begin
        cmd_o.acc_total = 1'b1;
        cmd_o.issue     = !stat_i.sweep_end;
        if (stat_i.sweep_end && !stat_i.rd_pend) begin
          state_d = S_SCALE;
        end
      end
      S_SCALE: begin
        cmd_o.scale     = 1'b1;
        cmd_o.sweep_clr = 1'b1;
        state_d         = stat_i.total_zero ? S_DONE : S_WALK;
      end
      S_WALK: begin
        cmd_o.acc_run = 1'b1;
        cmd_o.issue   = !stat_i.sweep_end && !stat_i.found;
        if (stat_i.found || (stat_i.sweep_end && !stat_i.rd_pend)) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        // hold until the output register can take the item
        if (!stat_i.out_busy) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

// File: rtl/rws_dpath.sv
// ----------------------------------------------------------------------------
// rws_dpath
// Fitness store, running sums, target scaling, parent memory, output register.
// ----------------------------------------------------------------------------
module rws_dpath import rws_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rws_cmd_t          cmd_i,
  output rws_stat_t         stat_o,
  input  logic              cfg_valid_i,
  input  logic [POP_W-1:0]  cfg_pop_size_i,
  input  logic [OP_W-1:0]   op_i,
  input  logic [IDX_W-1:0]  entry_index_i,
  input  logic [FIT_W-1:0]  fitness_value_i,
  input  logic [RAND_W-1:0] random_fraction_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [IDX_W-1:0]  chosen_index_o,
  output logic [STAT_W-1:0] status_o
);

  logic [FIT_W-1:0]          mem [POP_MAX];
  logic [POP_MAX-1:0]        vld_q;
  logic [POP_W-1:0]          pop_size_q;
  logic [CNT_W-1:0]          n_act;
  op_e                       op_q;
  logic [IDX_W-1:0]          idx_q;
  logic [RAND_FRAC_BITS-1:0] r_q;
  logic                      wr_ok_q;
  logic                      wr_ok;
  logic [CNT_W-1:0]          cnt_q;
  logic                      rd_pend_q;
  logic [IDX_W-1:0]          rd_addr_q;
  logic [FIT_W-1:0]          rd_data_q;
  logic                      rd_hit_q;
  logic [FIT_W-1:0]          rd_word;
  logic [SUM_W-1:0]          total_q;
  logic [SUM_W-1:0]          target_q;
  logic [SUM_W-1:0]          run_q;
  logic [SUM_W-1:0]          run_nxt;
  logic [PROD_W-1:0]         prod;
  logic                      found_q;
  logic [IDX_W-1:0]          pick_q;
  logic [IDX_W-1:0]          fp_q;
  logic                      fpv_q;
  logic                      out_valid_q;
  logic [IDX_W-1:0]          chosen_q;
  status_e                   status_q;
  logic [IDX_W-1:0]          res_idx;
  status_e                   res_stat;

  assign n_act   = (pop_size_q > POP_W'(POP_MAX)) ? CNT_W'(POP_MAX) : CNT_W'(pop_size_q);
  assign wr_ok   = CNT_W'(entry_index_i) < n_act;
  assign rd_word = rd_hit_q ? rd_data_q : '0;
  assign run_nxt = run_q + SUM_W'(rd_word);
  assign prod    = PROD_W'(total_q) * PROD_W'(r_q);

  // fitness store: one write port at capture, one read port for the sweeps
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture && (op_e'(op_i) == OP_WRITE) && wr_ok) begin
      mem[entry_index_i] <= fitness_value_i;
    end
    if (cmd_i.issue) begin
      rd_data_q <= mem[cnt_q[IDX_W-1:0]];
    end
  end

  // entries never written since reset read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_hit_q <= 1'b0;
    end else begin
      if (cmd_i.capture && (op_e'(op_i) == OP_WRITE) && wr_ok) begin
        vld_q[entry_index_i] <= 1'b1;
      end
      if (cmd_i.issue) begin
        rd_hit_q <= vld_q[cnt_q[IDX_W-1:0]];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pop_size_q  <= POP_RESET;
      cnt_q       <= '0;
      rd_pend_q   <= 1'b0;
      found_q     <= 1'b0;
      fp_q        <= '0;
      fpv_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        pop_size_q <= cfg_pop_size_i;
      end
      rd_pend_q <= cmd_i.issue;
      if (cmd_i.capture || cmd_i.sweep_clr) begin
        cnt_q <= '0;
      end else if (cmd_i.issue) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end
      if (cmd_i.sweep_clr) begin
        found_q <= 1'b0;
      end else if (cmd_i.acc_run && rd_pend_q && !found_q && (run_nxt > target_q)) begin
        found_q <= 1'b1;
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
        if ((op_q == OP_DRAW_FIRST) && (total_q == '0)) begin
          fpv_q <= 1'b0;
        end else if (op_q == OP_DRAW_FIRST) begin
          fpv_q <= 1'b1;
          fp_q  <= pick_q;
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q    <= op_e'(op_i);
      idx_q   <= entry_index_i;
      r_q     <= random_fraction_i[RAND_FRAC_BITS-1:0];
      wr_ok_q <= wr_ok;
      total_q <= '0;
    end else if (cmd_i.acc_total && rd_pend_q) begin
      total_q <= total_q + SUM_W'(rd_word);
    end
    if (cmd_i.issue) begin
      rd_addr_q <= cnt_q[IDX_W-1:0];
    end
    if (cmd_i.scale) begin
      target_q <= prod[PROD_W-1:RAND_FRAC_BITS];
    end
    if (cmd_i.sweep_clr) begin
      run_q  <= '0;
      pick_q <= IDX_W'(n_act - CNT_W'(1));
    end else if (cmd_i.acc_run && rd_pend_q && !found_q) begin
      run_q <= run_nxt;
      if (run_nxt > target_q) begin
        pick_q <= rd_addr_q;
      end
    end
    if (cmd_i.load_out) begin
      chosen_q <= res_idx;
      status_q <= res_stat;
    end
  end

  always_comb begin
    res_idx  = '0;
    res_stat = ST_OUT_RANGE;
    case (op_q)
      OP_WRITE: begin
        res_idx  = idx_q;
        res_stat = wr_ok_q ? ST_OK : ST_OUT_RANGE;
      end
      OP_DRAW_FIRST, OP_DRAW_SECOND: begin
        if (total_q == '0) begin
          res_stat = ST_ZERO_TOTAL;
        end else begin
          res_idx  = pick_q;
          res_stat = ((op_q == OP_DRAW_SECOND) && fpv_q && (pick_q == fp_q)) ?
                     ST_RETRY : ST_OK;
        end
      end
      default: begin
        res_idx  = '0;
        res_stat = ST_OUT_RANGE;
      end
    endcase
  end

  assign stat_o.sweep_end  = cnt_q >= n_act;
  assign stat_o.rd_pend    = rd_pend_q;
  assign stat_o.found      = found_q;
  assign stat_o.total_zero = total_q == '0;
  assign stat_o.out_busy   = out_valid_q && !out_ready_i;

  assign out_valid_o    = out_valid_q;
  assign chosen_index_o = chosen_q;
  assign status_o       = STAT_W'(status_q);

endmodule

// File: rtl/roulette_wheel_parent_select_unit.sv
// ----------------------------------------------------------------------------
// roulette_wheel_parent_select_unit
// Fitness-proportionate parent selection over a store of Q16.16 fitnesses.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i/in_ready_o) takes one item: op_i selects a
// fitness write, a first-parent draw or a second-parent draw. The output
// channel (out_valid_o/out_ready_i) returns one item per input: chosen_index_o
// and status_o. The configuration channel (cfg_valid_i/cfg_ready_o) writes
// pop_size; it is always ready. The user must write it only while the unit
// is idle; the unit itself does not enforce this. One item is worked on at
// a time. A write or unused op passes from accept through the done state
// into the output register. A draw sweeps the single read port of the
// fitness store over the first min(pop_size, 256) entries, one entry per
// cycle, once to form the total and again to find the cumulative crossing.
// A new item is accepted as soon as the previous result sits in the output
// register, even while the receiver stalls; the next result then waits in
// the controller until that register frees up.
// Reset clears all fitness entries (per-entry valid bits), sets pop_size to
// 256 and forgets the first parent. No clearing sweep is needed.
// ----------------------------------------------------------------------------
module roulette_wheel_parent_select_unit import rws_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [POP_W-1:0]  cfg_pop_size_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [OP_W-1:0]   op_i,
  input  logic [IDX_W-1:0]  entry_index_i,
  input  logic [FIT_W-1:0]  fitness_value_i,
  input  logic [RAND_W-1:0] random_fraction_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [IDX_W-1:0]  chosen_index_o,
  output logic [STAT_W-1:0] status_o
);

  rws_cmd_t  cmd;
  rws_stat_t stat;

  assign cfg_ready_o = 1'b1;

  rws_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .op_i       (op_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  rws_dpath u_dpath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_pop_size_i    (cfg_pop_size_i),
    .op_i              (op_i),
    .entry_index_i     (entry_index_i),
    .fitness_value_i   (fitness_value_i),
    .random_fraction_i (random_fraction_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .chosen_index_o    (chosen_index_o),
    .status_o          (status_o)
  );

endmodule

// File: rtl/rws_checker.sv
// ----------------------------------------------------------------------------
// rws_checker
// Port-level checks for the roulette-wheel parent selection unit.
// ----------------------------------------------------------------------------
module rws_checker import rws_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input logic [IDX_W-1:0]  chosen_index_o,
  input logic [STAT_W-1:0] status_o
);

  // a stalled result must hold
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(chosen_index_o)
      && $stable(status_o))
    else $error("output item changed while stalled");

  // one item at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted twice in a row");

  // a fresh result only comes out of a busy cycle
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result appeared without work");

  // a zero-total draw always reports entry zero
  a_zero_total_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == STAT_W'(ST_ZERO_TOTAL)) |-> chosen_index_o == '0)
    else $error("zero total with nonzero index");

endmodule

bind roulette_wheel_parent_select_unit rws_checker u_rws_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .chosen_index_o (chosen_index_o),
  .status_o       (status_o)
);

// File: tb/sv/tb_roulette_wheel_parent_select_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_roulette_wheel_parent_select_unit
// Self-checking bench for the roulette-wheel parent selection unit. A short
// table of directed items covers reset state, field extremes, each op and the
// retry, zero-total and out-of-range cases. Random phases follow, each with
// its own pop_size and fitness profile. A behavioral predictor tracks the
// fitness store and the first parent and checks every result in order.
// ----------------------------------------------------------------------------
module tb_roulette_wheel_parent_select_unit;
  import rws_pkg::*;

  localparam int QUIET_LIMIT   = 4000;
  localparam int DRAIN_CYCLES  = 600;
  localparam int RANDOM_ITEMS  = 1000;

  typedef struct {
    bit                is_cfg;
    logic [POP_W-1:0]  pop;
    op_e               op;
    logic [IDX_W-1:0]  idx;
    logic [FIT_W-1:0]  fit;
    logic [RAND_W-1:0] frac;
    bit                typed;
    logic [IDX_W-1:0]  want_idx;
    status_e           want_st;
  } step_t;

  typedef struct {
    logic [IDX_W-1:0] want_idx;
    status_e          want_st;
    op_e              op;
    int               serial;
  } selection_t;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_valid_i;
  logic              cfg_ready_o;
  logic [POP_W-1:0]  cfg_pop_size_i;
  logic              in_valid_i;
  logic              in_ready_o;
  logic [OP_W-1:0]   op_i;
  logic [IDX_W-1:0]  entry_index_i;
  logic [FIT_W-1:0]  fitness_value_i;
  logic [RAND_W-1:0] random_fraction_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic [IDX_W-1:0]  chosen_index_o;
  logic [STAT_W-1:0] status_o;

  // predictor state
  logic [FIT_W-1:0]  fitness_m [POP_MAX] = '{default: '0};
  logic [POP_W-1:0]  pop_size_m = POP_RESET;
  logic [IDX_W-1:0]  first_parent_m = '0;
  bit                first_valid_m = 1'b0;

  selection_t        pending_results [$];
  selection_t        head_result;
  bit                steady_mode = 1'b0;
  int                mismatches = 0;
  int                items_issued = 0;
  int                results_checked = 0;
  int                cfg_writes = 0;
  int                draws_issued = 0;
  int                retries_expected = 0;
  int                zero_totals_expected = 0;
  int                quiet_cycles = 0;
  int                hold_cycles = 0;
  int                run_cycles = 0;

  step_t directed_steps [25] = '{
    // store is all zero after reset
    '{1'b0, 9'd0, OP_DRAW_FIRST,  8'h00, 32'h0000_0000, 16'h0000, 1'b1, 8'd0,   ST_ZERO_TOTAL},
    '{1'b0, 9'd0, OP_DRAW_SECOND, 8'hFF, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, 8'd0,   ST_ZERO_TOTAL},
    '{1'b0, 9'd0, OP_NONE,        8'hFF, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, 8'd0,   ST_OUT_RANGE},
    '{1'b0, 9'd0, OP_WRITE,       8'h00, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, 8'd0,   ST_OK},
    '{1'b0, 9'd0, OP_WRITE,       8'hFF, 32'h0000_0001, 16'h0000, 1'b1, 8'd255, ST_OK},
    '{1'b0, 9'd0, OP_WRITE,       8'h80, 32'h0000_0000, 16'h0000, 1'b1, 8'd128, ST_OK},
    '{1'b0, 9'd0, OP_DRAW_FIRST,  8'h00, 32'h0000_0000, 16'h0000, 1'b1, 8'd0,   ST_OK},
    '{1'b0, 9'd0, OP_DRAW_SECOND, 8'h00, 32'h0000_0000, 16'h0000, 1'b1, 8'd0,   ST_RETRY},
    '{1'b0, 9'd0, OP_DRAW_SECOND, 8'h55, 32'hAAAA_5555, 16'hFFFF, 1'b0, 8'd0,   ST_OK},
    '{1'b0, 9'd0, OP_WRITE,       8'h00, 32'h0000_0001, 16'h0000, 1'b1, 8'd0,   ST_OK},
    // zero-fitness entries in between are skipped
    '{1'b0, 9'd0, OP_DRAW_SECOND, 8'hAA, 32'h5555_AAAA, 16'hFFFF, 1'b0, 8'd0,   ST_OK},
    '{1'b1, 9'd2, OP_WRITE,       8'h00, 32'h0000_0000, 16'h0000, 1'b0, 8'd0,   ST_OK},
    '{1'b0, 9'd0, OP_WRITE,       8'h02, 32'h0000_0007, 16'h0000, 1'b1, 8'd2,   ST_OUT_RANGE},
    '{1'b0, 9'd0, OP_WRITE,       8'hFF, 32'h0000_0007, 16'h0000, 1'b1, 8'd255, ST_OUT_RANGE},
    '{1'b0, 9'd0, OP_WRITE,       8'h01, 32'h0000_0005, 16'h0000, 1'b1, 8'd1,   ST_OK},
    '{1'b0, 9'd0, OP_DRAW_FIRST,  8'h00, 32'h0000_0000, 16'h8000, 1'b0, 8'd0,   ST_OK},
    '{1'b0, 9'd0, OP_DRAW_SECOND, 8'h00, 32'h0000_0000, 16'h1234, 1'b0, 8'd0,   ST_OK},
    // single entry: every second draw collides
    '{1'b1, 9'd1, OP_WRITE,       8'h00, 32'h0000_0000, 16'h0000, 1'b0, 8'd0,   ST_OK},
    '{1'b0, 9'd0, OP_DRAW_FIRST,  8'h00, 32'h0000_0000, 16'h0000, 1'b1, 8'd0,   ST_OK},
    '{1'b0, 9'd0, OP_DRAW_SECOND, 8'h00, 32'h0000_0000, 16'hFFFF, 1'b1, 8'd0,   ST_RETRY},
    '{1'b0, 9'd0, OP_WRITE,       8'h01, 32'h0000_0009, 16'h0000, 1'b1, 8'd1,   ST_OUT_RANGE},
    '{1'b1, 9'd0, OP_WRITE,       8'h00, 32'h0000_0000, 16'h0000, 1'b0, 8'd0,   ST_OK},
    '{1'b0, 9'd0, OP_DRAW_FIRST,  8'h00, 32'h0000_0000, 16'h0000, 1'b1, 8'd0,   ST_ZERO_TOTAL},
    // oversized pop_size clamps to the full store; first parent was dropped
    '{1'b1, 9'd511, OP_WRITE,     8'h00, 32'h0000_0000, 16'h0000, 1'b0, 8'd0,   ST_OK},
    '{1'b0, 9'd0, OP_DRAW_SECOND, 8'h00, 32'h0000_0000, 16'h0000, 1'b1, 8'd0,   ST_OK}
  };

  roulette_wheel_parent_select_unit u_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_pop_size_i    (cfg_pop_size_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .op_i              (op_i),
    .entry_index_i     (entry_index_i),
    .fitness_value_i   (fitness_value_i),
    .random_fraction_i (random_fraction_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .chosen_index_o    (chosen_index_o),
    .status_o          (status_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Spin the wheel over the active entries and update parent/store state.
  function automatic void predict_selection(input op_e op, input logic [IDX_W-1:0] idx,
                                            input logic [FIT_W-1:0] fit,
                                            input logic [RAND_W-1:0] frac,
                                            output logic [IDX_W-1:0] pick,
                                            output status_e st);
    logic [SUM_W-1:0]  total;
    logic [SUM_W-1:0]  run;
    logic [PROD_W-1:0] target;
    int                n;
    int                i;
    bit                hit;
    n = (pop_size_m > POP_W'(256)) ? 256 : int'(pop_size_m);
    total = '0;
    for (i = 0; i < n; i++) total += SUM_W'(fitness_m[i]);
    target = (PROD_W'(total) * PROD_W'(frac)) >> RAND_FRAC_BITS;
    run = '0;
    hit = 1'b0;
    pick = '0;
    for (i = 0; i < n; i++) begin
      if (!hit) begin
        run += SUM_W'(fitness_m[i]);
        if (PROD_W'(run) > target) begin
          pick = IDX_W'(i);
          hit = 1'b1;
        end
      end
    end
    st = ST_OK;
    case (op)
      OP_WRITE: begin
        pick = idx;
        if (int'(idx) < n) fitness_m[idx] = fit;
        else st = ST_OUT_RANGE;
      end
      OP_DRAW_FIRST: begin
        if (total == '0) begin
          pick = '0;
          st = ST_ZERO_TOTAL;
          first_valid_m = 1'b0;
        end else begin
          first_parent_m = pick;
          first_valid_m = 1'b1;
        end
      end
      OP_DRAW_SECOND: begin
        if (total == '0) begin
          pick = '0;
          st = ST_ZERO_TOTAL;
        end else if (first_valid_m && pick == first_parent_m) begin
          st = ST_RETRY;
        end
      end
      default: begin
        pick = '0;
        st = ST_OUT_RANGE;
      end
    endcase
  endfunction

  task automatic flag_mismatch(input string msg);
    mismatches++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  function automatic int gap_length();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(15, 60) : $urandom_range(1, 3);
  endfunction

  function automatic logic [FIT_W-1:0] pick_fitness(input int profile);
    case (profile)
      0: return $urandom;
      1: return ($urandom_range(0, 2) == 0) ? '0 : FIT_W'($urandom_range(1, 255));
      2: return ($urandom_range(0, 4) == 0) ? FIT_W'($urandom) : '0;
      3: return '0;
      default: return ($urandom_range(0, 1) == 0) ? '1 : ($urandom | 32'hF000_0000);
    endcase
  endfunction

  function automatic logic [RAND_W-1:0] pick_fraction();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return RAND_W'($urandom);
    endcase
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic issue_item(input op_e op, input logic [IDX_W-1:0] idx,
                            input logic [FIT_W-1:0] fit, input logic [RAND_W-1:0] frac,
                            input bit typed = 1'b0, input logic [IDX_W-1:0] want_idx = '0,
                            input status_e want_st = ST_OK);
    int               gap;
    logic [IDX_W-1:0] p_idx;
    status_e          p_st;
    selection_t       entry;
    gap = (steady_mode || $urandom_range(0, 2) != 0) ? 0 : gap_length();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    op_i              <= op;
    entry_index_i     <= idx;
    fitness_value_i   <= fit;
    random_fraction_i <= frac;
    in_valid_i        <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_selection(op, idx, fit, frac, p_idx, p_st);
    entry.want_idx = typed ? want_idx : p_idx;
    entry.want_st  = typed ? want_st : p_st;
    entry.op       = op;
    entry.serial   = items_issued;
    pending_results.insert(pending_results.size(), entry);
    items_issued++;
    if (op == OP_DRAW_FIRST || op == OP_DRAW_SECOND) draws_issued++;
    if (entry.want_st == ST_RETRY) retries_expected++;
    if (entry.want_st == ST_ZERO_TOTAL) zero_totals_expected++;
    @(negedge clk_i);
  endtask

  // Drain all results, then write pop_size while the unit is idle.
  task automatic write_pop_size(input logic [POP_W-1:0] pop);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    cfg_pop_size_i <= pop;
    cfg_valid_i    <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    pop_size_m = pop;
    cfg_writes++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic run_phase(input logic [POP_W-1:0] pop, input int budget);
    int n;
    int profile;
    int start;
    int choice;
    int k;
    n = (pop > POP_W'(256)) ? 256 : int'(pop);
    profile = $urandom_range(0, 4);
    steady_mode = ($urandom_range(0, 3) == 0);
    write_pop_size(pop);
    start = items_issued;
    // load the wheel: every slot for small sizes, a scatter for large ones
    if (n <= 32) begin
      for (k = 0; k < n; k++)
        issue_item(OP_WRITE, IDX_W'(k), pick_fitness(profile), RAND_W'($urandom));
    end else begin
      repeat (24)
        issue_item(OP_WRITE, IDX_W'($urandom_range(0, n - 1)), pick_fitness(profile),
                   RAND_W'($urandom));
    end
    while (items_issued - start < budget) begin
      choice = $urandom_range(0, 99);
      if (choice < 55) begin
        issue_item(OP_DRAW_FIRST, IDX_W'($urandom), $urandom, pick_fraction());
        repeat ($urandom_range(1, 3))
          issue_item(OP_DRAW_SECOND, IDX_W'($urandom), $urandom, pick_fraction());
      end else if (choice < 70) begin
        issue_item(OP_WRITE, IDX_W'($urandom_range(0, n - 1)), pick_fitness(profile),
                   RAND_W'($urandom));
      end else if (choice < 80) begin
        issue_item(OP_WRITE, IDX_W'($urandom), $urandom, RAND_W'($urandom));
      end else if (choice < 88) begin
        issue_item(OP_DRAW_SECOND, IDX_W'($urandom), $urandom, pick_fraction());
      end else if (choice < 95) begin
        issue_item(OP_NONE, IDX_W'($urandom), $urandom, RAND_W'($urandom));
      end else begin
        issue_item(OP_DRAW_FIRST, IDX_W'($urandom), $urandom, pick_fraction());
      end
    end
  endtask

  // receiver: bursts of ready broken by short and occasional long stalls
  initial begin
    out_ready_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (hold_cycles == 0 && run_cycles == 0) begin
        if (!steady_mode && $urandom_range(0, 3) == 0) hold_cycles = gap_length();
        else run_cycles = $urandom_range(1, 24);
      end
      if (hold_cycles > 0) begin
        out_ready_i <= 1'b0;
        hold_cycles--;
      end else begin
        out_ready_i <= 1'b1;
        run_cycles--;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        flag_mismatch($sformatf("result idx=%0d st=%0d with nothing pending",
                                chosen_index_o, status_o));
      end else begin
        head_result = pending_results.pop_front();
        results_checked++;
        if (chosen_index_o !== head_result.want_idx)
          flag_mismatch($sformatf("item %0d (%s): chosen_index %0d, want %0d",
                                  head_result.serial, head_result.op.name(),
                                  chosen_index_o, head_result.want_idx));
        if (status_o !== head_result.want_st)
          flag_mismatch($sformatf("item %0d (%s): status %0d, want %s",
                                  head_result.serial, head_result.op.name(),
                                  status_o, head_result.want_st.name()));
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: %0d cycles without a handshake, %0d results pending",
               quiet_cycles, pending_results.size());
      $display("tb_roulette_wheel_parent_select_unit NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int               phase_no;
    int               directed_items;
    logic [POP_W-1:0] pop;
    rst_ni            = 1'b0;
    cfg_valid_i       = 1'b0;
    cfg_pop_size_i    = POP_RESET;
    in_valid_i        = 1'b0;
    op_i              = OP_NONE;
    entry_index_i     = '0;
    fitness_value_i   = '0;
    random_fraction_i = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed_steps[i]) begin
      if (directed_steps[i].is_cfg)
        write_pop_size(directed_steps[i].pop);
      else
        issue_item(directed_steps[i].op, directed_steps[i].idx, directed_steps[i].fit,
                   directed_steps[i].frac, directed_steps[i].typed,
                   directed_steps[i].want_idx, directed_steps[i].want_st);
    end
    directed_items = items_issued;

    // mostly small wheels; the full 256-entry wheel now and then
    phase_no = 0;
    while (items_issued - directed_items < RANDOM_ITEMS) begin
      if (phase_no == 0) pop = POP_W'(2);
      else if (phase_no == 1 || phase_no % 5 == 4) pop = POP_W'(256);
      else pop = POP_W'($urandom_range(2, 32));
      run_phase(pop, (pop == POP_W'(256)) ? 60 : 80);
      phase_no++;
    end

    in_valid_i <= 1'b0;
    steady_mode = 1'b1;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Run covered %0d items (%0d draws, %0d retries, %0d zero totals) over %0d phases",
             items_issued, draws_issued, retries_expected, zero_totals_expected, phase_no);
    $display("with %0d pop_size writes; %0d results checked, %0d mismatches",
             cfg_writes, results_checked, mismatches);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("tb_roulette_wheel_parent_select_unit OK");
    end else begin
      $display("tb_roulette_wheel_parent_select_unit NOT OK");
    end
    $finish;
  end

endmodule
